// File: src/tbi_pkg.sv
// Shared types and constants for the table bilinear interpolator.
// Used by the channel interfaces, the divider and the top level.
`default_nettype none

package tbi_pkg;

	localparam int MAX_X_POINTS = 32;
	localparam int MAX_Y_POINTS = 32;
	localparam int IDX_W        = 5;
	localparam int CNT_W        = 6;
	localparam int ADDR_W       = 10;
	localparam int VAL_W        = 32;
	localparam int GRID_DEPTH   = MAX_X_POINTS * MAX_Y_POINTS;
	localparam int PADDR_W      = 3;

	// serial divider: |pos - low| << 16 over |up - low|
	localparam int DIV_NUM_W = 48;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = 6;

	typedef enum logic [1:0] {
		OP_WR_X    = 2'd0,
		OP_WR_Y    = 2'd1,
		OP_WR_GRID = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_CORNER   = 2'd0,
		MODE_LERP_X   = 2'd1,
		MODE_LERP_Y   = 2'd2,
		MODE_BILINEAR = 2'd3
	} mode_t;

	typedef enum logic {
		REG_X_COUNT = 1'b0,
		REG_Y_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_X,
		ST_SCAN_Y,
		ST_ROW,
		ST_FETCH,
		ST_SETUP,
		ST_START,
		ST_DIV,
		ST_SAT,
		ST_MUL,
		ST_SCALE,
		ST_SUM,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t                      opcode;
		logic [ADDR_W-1:0]        address;
		logic signed [VAL_W-1:0]  write_value;
		logic signed [VAL_W-1:0]  query_x;
		logic signed [VAL_W-1:0]  query_y;
		mode_t                    mode;
	} cmd_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  result_value;
		logic [IDX_W-1:0]         x_index;
		logic [IDX_W-1:0]         y_index;
	} rsp_item_t;

endpackage

`default_nettype wire

// File: src/tbi_cmd_if.sv
// Command channel: write and query transactions into the interpolator.
// Depends on tbi_pkg for the payload type.
`default_nettype none

interface tbi_cmd_if;
	import tbi_pkg::*;

	logic      valid;
	logic      ready;
	cmd_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/tbi_rsp_if.sv
// Response channel: one result transaction per query.
// Depends on tbi_pkg for the payload type.
`default_nettype none

interface tbi_rsp_if;
	import tbi_pkg::*;

	logic      valid;
	logic      ready;
	rsp_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/tbi_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tbi_pkg for operand widths.
`default_nettype none

module tbi_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tbi_pkg::DIV_NUM_W-1:0] dividend,
	input  logic [tbi_pkg::DIV_DEN_W-1:0] divisor,
	output logic                          done,
	output logic [tbi_pkg::DIV_NUM_W-1:0] quotient
);
	import tbi_pkg::*;

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] dq_q;

	logic [DIV_DEN_W:0]   trial;
	logic                 ge;
	logic [DIV_DEN_W:0]   diff;

	always_comb begin
		trial = {rem_q, dq_q[DIV_NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 1'b1;
			done_q <= cnt_q == LAST_STEP;
			busy_q <= cnt_q != LAST_STEP;
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder stays below the divisor, so its top bit is dropped
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			dq_q  <= {dq_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

`default_nettype wire

// File: src/table_bilinear_interpolator.sv
// Sequence: a write gives no result. A query scans x then y, one breakpoint a cycle, then
// computes the row addresses and reads the four corners, then runs one interpolation pass per
// axis step (none, one, or three for bilinear); each pass runs the shared 48-step serial
// divider, or skips it when the breakpoints are equal. The result then goes to the output
// register once that register is empty or being read; one query at a time.
// Reset: counts go to 1, control clears; breakpoint and table stores are undefined until written.
`default_nettype none

module table_bilinear_interpolator (
	input  logic                        clk,
	input  logic                        arst_n,
	tbi_cmd_if.sink                     cmd,
	tbi_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tbi_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import tbi_pkg::*;

	localparam logic [1:0] CNR_LL = 2'd0;
	localparam logic [1:0] CNR_LU = 2'd1;
	localparam logic [1:0] CNR_UL = 2'd2;
	localparam logic [1:0] CNR_UU = 2'd3;
	localparam logic [2:0] FETCH_END = 3'd4;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	// configuration
	logic [CNT_W-1:0] xcnt_q, ycnt_q;
	logic             cfg_wr;
	reg_idx_t         cfg_sel;

	// storage
	logic signed [VAL_W-1:0] xb_q [MAX_X_POINTS];
	logic signed [VAL_W-1:0] yb_q [MAX_Y_POINTS];
	logic signed [VAL_W-1:0] grid_mem [GRID_DEPTH];
	logic signed [VAL_W-1:0] grid_rd_q;
	logic [ADDR_W-1:0]       grid_raddr;

	// sequencer
	state_t state_q, state_d;
	logic   accept, div_start, rsp_load;
	logic   rsp_valid_q;
	rsp_item_t rsp_data_q;

	// query context
	logic signed [VAL_W-1:0] qx_q, qy_q;
	mode_t                   mode_q;
	logic [IDX_W-1:0]        xlast_q, ylast_q, xlast_w, ylast_w;
	logic [IDX_W-1:0]        i_q;
	logic signed [VAL_W-1:0] prev_q;
	logic [IDX_W-1:0]        xl_q, xu_q, yl_q, yu_q;
	logic signed [VAL_W-1:0] xlo_q, xup_q, ylo_q, yup_q;
	logic [ADDR_W-1:0]       rowl_q, rowu_q;
	logic [CNT_W-1:0]        ny_w;
	logic [2:0]              fidx_q;
	logic [1:0]              cidx;
	logic signed [VAL_W-1:0] corner_q [4];
	logic [1:0]              pass_q;
	logic signed [VAL_W-1:0] res_q [2];

	// scan compare
	logic signed [VAL_W-1:0] xb_rd, yb_rd;
	logic                    x_hit, y_hit;

	// interpolation datapath
	logic signed [VAL_W-1:0] op_base, op_other, op_pos, op_lo, op_up;
	logic signed [VAL_W-1:0] base_q, lerp_q, frac_q, frac_w;
	logic signed [VAL_W:0]   delta_q, num_q, span_q;
	logic                    neg_q;
	logic signed [64:0]      prod_q, scaled_w;
	logic signed [48:0]      t_q;
	logic signed [49:0]      sum_w;
	logic [VAL_W:0]          abs_num, abs_span;
	logic [DIV_NUM_W-1:0]    div_dividend, div_quot;
	logic [DIV_DEN_W-1:0]    div_divisor;
	logic                    div_done;

	// ---------------------------------------------------------------- config port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (cfg_sel)
			REG_X_COUNT: prdata = 32'(xcnt_q);
			REG_Y_COUNT: prdata = 32'(ycnt_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xcnt_q <= CNT_W'(1);
			ycnt_q <= CNT_W'(1);
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_X_COUNT: xcnt_q <= pwdata[CNT_W-1:0];
				REG_Y_COUNT: ycnt_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective counts, held as last valid index
	always_comb begin
		if (xcnt_q == '0)
			xlast_w = '0;
		else if (xcnt_q > CNT_W'(MAX_X_POINTS))
			xlast_w = IDX_W'(MAX_X_POINTS - 1);
		else
			xlast_w = IDX_W'(xcnt_q - 1'b1);
		if (ycnt_q == '0)
			ylast_w = '0;
		else if (ycnt_q > CNT_W'(MAX_Y_POINTS))
			ylast_w = IDX_W'(MAX_Y_POINTS - 1);
		else
			ylast_w = IDX_W'(ycnt_q - 1'b1);
	end

	// ---------------------------------------------------------------- storage
	assign accept = cmd.valid && cmd.ready;

	always_ff @(posedge clk) begin
		if (accept && cmd.data.opcode == OP_WR_X && cmd.data.address < ADDR_W'(MAX_X_POINTS))
			xb_q[cmd.data.address[IDX_W-1:0]] <= cmd.data.write_value;
		if (accept && cmd.data.opcode == OP_WR_Y && cmd.data.address < ADDR_W'(MAX_Y_POINTS))
			yb_q[cmd.data.address[IDX_W-1:0]] <= cmd.data.write_value;
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.data.opcode == OP_WR_GRID)
			grid_mem[cmd.data.address] <= cmd.data.write_value;
		grid_rd_q <= grid_mem[grid_raddr];
	end

	// fetch order follows corner code: bit 0 picks the y index, bit 1 the x row
	assign grid_raddr = (fidx_q[1] ? rowu_q : rowl_q)
		+ {{(ADDR_W-IDX_W){1'b0}}, (fidx_q[0] ? yu_q : yl_q)};
	assign cidx = 2'(fidx_q - 3'd1);
	assign ny_w = {1'b0, ylast_q} + 1'b1;

	// ---------------------------------------------------------------- scan compare
	assign xb_rd = xb_q[i_q];
	assign yb_rd = yb_q[i_q];
	assign x_hit = qx_q < xb_rd;
	assign y_hit = qy_q < yb_rd;

	// ---------------------------------------------------------------- pass operands
	always_comb begin
		case (pass_q)
			2'd0: begin
				op_base = corner_q[CNR_LL];
				if (mode_q == MODE_LERP_Y) begin
					op_other = corner_q[CNR_LU];
					op_pos   = qy_q;
					op_lo    = ylo_q;
					op_up    = yup_q;
				end else begin
					op_other = corner_q[CNR_UL];
					op_pos   = qx_q;
					op_lo    = xlo_q;
					op_up    = xup_q;
				end
			end
			2'd1: begin
				op_base  = corner_q[CNR_LU];
				op_other = corner_q[CNR_UU];
				op_pos   = qx_q;
				op_lo    = xlo_q;
				op_up    = xup_q;
			end
			default: begin
				op_base  = res_q[0];
				op_other = res_q[1];
				op_pos   = qy_q;
				op_lo    = ylo_q;
				op_up    = yup_q;
			end
		endcase
	end

	// divider operands are magnitudes; sign is applied after
	assign abs_num      = num_q[VAL_W] ? (33'd0 - num_q) : num_q;
	assign abs_span     = span_q[VAL_W] ? (33'd0 - span_q) : span_q;
	assign div_dividend = {abs_num[VAL_W-1:0], 16'd0};
	assign div_divisor  = abs_span[VAL_W-1:0];

	tbi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// saturate the signed fraction
	always_comb begin
		if (!neg_q) begin
			if (div_quot[DIV_NUM_W-1:VAL_W-1] != '0)
				frac_w = VAL_MAX;
			else
				frac_w = div_quot[VAL_W-1:0];
		end else begin
			if (div_quot[DIV_NUM_W-1:VAL_W] != '0
					|| (div_quot[VAL_W-1] && div_quot[VAL_W-2:0] != '0))
				frac_w = VAL_MIN;
			else
				frac_w = 32'd0 - div_quot[VAL_W-1:0];
		end
	end

	// divide by 65536 truncating toward zero
	assign scaled_w = prod_q + (prod_q[64] ? 65'sd65535 : 65'sd0);
	assign sum_w    = 50'(base_q) + 50'(t_q);

	// ---------------------------------------------------------------- state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		rsp_load  = 1'b0;
		cmd.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid && cmd.data.opcode == OP_QUERY)
					state_d = ST_SCAN_X;
			end
			ST_SCAN_X: begin
				if (x_hit || i_q == xlast_q)
					state_d = ST_SCAN_Y;
			end
			ST_SCAN_Y: begin
				if (y_hit || i_q == ylast_q)
					state_d = ST_ROW;
			end
			ST_ROW:   state_d = ST_FETCH;
			ST_FETCH: begin
				if (fidx_q == FETCH_END)
					state_d = (mode_q == MODE_CORNER) ? ST_DONE : ST_SETUP;
			end
			ST_SETUP: state_d = (op_up == op_lo) ? ST_NEXT : ST_START;
			ST_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_SAT;
			end
			ST_SAT:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_SCALE;
			ST_SCALE: state_d = ST_SUM;
			ST_SUM:   state_d = ST_NEXT;
			ST_NEXT: begin
				if (mode_q == MODE_BILINEAR && pass_q != 2'd2)
					state_d = ST_SETUP;
				else
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				qx_q    <= cmd.data.query_x;
				qy_q    <= cmd.data.query_y;
				mode_q  <= cmd.data.mode;
				xlast_q <= xlast_w;
				ylast_q <= ylast_w;
				i_q     <= '0;
				pass_q  <= '0;
			end
			ST_SCAN_X: begin
				prev_q <= xb_rd;
				if (x_hit) begin
					xl_q  <= (i_q == '0) ? '0 : i_q - 1'b1;
					xu_q  <= i_q;
					xlo_q <= (i_q == '0) ? xb_rd : prev_q;
					xup_q <= xb_rd;
					i_q   <= '0;
				end else if (i_q == xlast_q) begin
					xl_q  <= i_q;
					xu_q  <= i_q;
					xlo_q <= xb_rd;
					xup_q <= xb_rd;
					i_q   <= '0;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_SCAN_Y: begin
				prev_q <= yb_rd;
				if (y_hit) begin
					yl_q  <= (i_q == '0) ? '0 : i_q - 1'b1;
					yu_q  <= i_q;
					ylo_q <= (i_q == '0) ? yb_rd : prev_q;
					yup_q <= yb_rd;
				end else if (i_q == ylast_q) begin
					yl_q  <= i_q;
					yu_q  <= i_q;
					ylo_q <= yb_rd;
					yup_q <= yb_rd;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_ROW: begin
				rowl_q <= {{(ADDR_W-IDX_W){1'b0}}, xl_q} * {{(ADDR_W-CNT_W){1'b0}}, ny_w};
				rowu_q <= {{(ADDR_W-IDX_W){1'b0}}, xu_q} * {{(ADDR_W-CNT_W){1'b0}}, ny_w};
				fidx_q <= '0;
			end
			ST_FETCH: begin
				fidx_q <= fidx_q + 1'b1;
				if (fidx_q != '0)
					corner_q[cidx] <= grid_rd_q;
				if (fidx_q == FETCH_END)
					lerp_q <= corner_q[CNR_LL];
			end
			ST_SETUP: begin
				base_q  <= op_base;
				lerp_q  <= op_base;
				delta_q <= 33'(op_other) - 33'(op_base);
				num_q   <= 33'(op_pos) - 33'(op_lo);
				span_q  <= 33'(op_up) - 33'(op_lo);
			end
			ST_START: neg_q <= num_q[VAL_W] ^ span_q[VAL_W];
			ST_SAT:   frac_q <= frac_w;
			ST_MUL:   prod_q <= 65'(frac_q) * 65'(delta_q);
			ST_SCALE: t_q <= scaled_w[64:16];
			ST_SUM: begin
				if (!sum_w[49] && sum_w[48:31] != '0)
					lerp_q <= VAL_MAX;
				else if (sum_w[49] && sum_w[48:31] != '1)
					lerp_q <= VAL_MIN;
				else
					lerp_q <= sum_w[VAL_W-1:0];
			end
			ST_NEXT: begin
				if (mode_q == MODE_BILINEAR && pass_q != 2'd2) begin
					res_q[pass_q[0]] <= lerp_q;
					pass_q <= pass_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (rsp_load)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_data_q.result_value <= lerp_q;
			rsp_data_q.x_index      <= xl_q;
			rsp_data_q.y_index      <= yl_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for table_bilinear_interpolator: loads breakpoints and tables,
// then checks query results against an in-bench Q16.16 lookup predictor.
// Depends on tbi_pkg, tbi_cmd_if, tbi_rsp_if and the interpolator RTL.

module testbench;
	import tbi_pkg::*;

	localparam int Q_MIN = 32'sh8000_0000;
	localparam int Q_MAX = 32'sh7FFF_FFFF;
	localparam int Q_ONE = 32'sh0001_0000;

	typedef enum {ROW_CFG, ROW_ITEM, ROW_CHECK} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		cmd_item_t  cmd;
		rsp_item_t  rsp;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	tbi_cmd_if cmd_ch ();
	tbi_rsp_if rsp_ch ();

	table_bilinear_interpolator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor copy of the block's stores and count registers
	int signed x_bp [MAX_X_POINTS];
	int signed y_bp [MAX_Y_POINTS];
	int signed grid_mem [GRID_DEPTH];
	logic [CNT_W-1:0] cfg_x_count;
	logic [CNT_W-1:0] cfg_y_count;

	rsp_item_t pending_results [$];
	rsp_item_t oldest;
	dir_row_t directed [$];

	int mismatch_count = 0;
	int results_checked = 0;
	int items_sent = 0;
	int phase_count = 0;
	int mode_hits [4] = '{0, 0, 0, 0};
	int stall_left = 0;
	bit hold_off_request = 1'b0;
	bit idle_enabled = 1'b1;

	int sched_x [11] = '{1, 2, 4, 0, 5, 3, 32, 6, 2, 63, 3};
	int sched_y [11] = '{1, 3, 2, 3, 5, 63, 32, 1, 7, 0, 4};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#(50_000_000);
		$display("table_bilinear_interpolator: mismatch");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("ERROR @%0t %s: got %h, want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	function automatic int signed clip_q(input longint signed v);
		if (v > longint'(Q_MAX))
			return Q_MAX;
		if (v < longint'(Q_MIN))
			return Q_MIN;
		return int'(v);
	endfunction

	function automatic int in_use(input logic [CNT_W-1:0] c, input int cap);
		if (c == 0)
			return 1;
		return (c > cap) ? cap : int'(c);
	endfunction

	// lower/upper index around q: first breakpoint strictly above q
	function automatic void locate(input bit on_y, input int signed q, input int n,
		output int lo, output int hi);
		int i;
		int signed b;
		bit found;
		found = 1'b0;
		lo = n - 1;
		hi = n - 1;
		for (i = 0; i < n && !found; i++) begin
			b = on_y ? y_bp[i] : x_bp[i];
			if (q < b) begin
				lo = (i == 0) ? 0 : i - 1;
				hi = i;
				found = 1'b1;
			end
		end
	endfunction

	function automatic int signed blend(input int signed base, other, pos, low, up);
		longint signed span, frac, delta;
		if (up == low)
			return base;
		span = longint'(up) - longint'(low);
		frac = ((longint'(pos) - longint'(low)) * 65536) / span;
		frac = longint'(clip_q(frac));
		delta = longint'(other) - longint'(base);
		return clip_q(longint'(base) + (frac * delta) / 65536);
	endfunction

	// applies one accepted transaction; returns 1 when a result is due
	function automatic bit model_item(input cmd_item_t c, output rsp_item_t r);
		int nx, ny, xl, xu, yl, yu;
		int signed ll, lu, ul, uu, v, a, b;
		r = '0;
		case (c.opcode)
			OP_WR_X: begin
				if (c.address < MAX_X_POINTS)
					x_bp[c.address] = c.write_value;
				return 1'b0;
			end
			OP_WR_Y: begin
				if (c.address < MAX_Y_POINTS)
					y_bp[c.address] = c.write_value;
				return 1'b0;
			end
			OP_WR_GRID: begin
				if (c.address < GRID_DEPTH)
					grid_mem[c.address] = c.write_value;
				return 1'b0;
			end
			default: ;
		endcase
		nx = in_use(cfg_x_count, MAX_X_POINTS);
		ny = in_use(cfg_y_count, MAX_Y_POINTS);
		locate(1'b0, c.query_x, nx, xl, xu);
		locate(1'b1, c.query_y, ny, yl, yu);
		ll = grid_mem[xl * ny + yl];
		lu = grid_mem[xl * ny + yu];
		ul = grid_mem[xu * ny + yl];
		uu = grid_mem[xu * ny + yu];
		case (c.mode)
			MODE_LERP_X: v = blend(ll, ul, c.query_x, x_bp[xl], x_bp[xu]);
			MODE_LERP_Y: v = blend(ll, lu, c.query_y, y_bp[yl], y_bp[yu]);
			MODE_BILINEAR: begin
				a = blend(ll, ul, c.query_x, x_bp[xl], x_bp[xu]);
				b = blend(lu, uu, c.query_x, x_bp[xl], x_bp[xu]);
				v = blend(a, b, c.query_y, y_bp[yl], y_bp[yu]);
			end
			default: v = ll;
		endcase
		r.result_value = v;
		r.x_index = xl[IDX_W-1:0];
		r.y_index = yl[IDX_W-1:0];
		return 1'b1;
	endfunction

	function automatic dir_row_t row(input row_kind_t k, input op_t op, input int addr,
		input int wv, input int qx, input int qy, input mode_t m, input int ev,
		input int exi, input int eyi);
		dir_row_t d;
		d.kind = k;
		d.cmd.opcode = op;
		d.cmd.address = addr[ADDR_W-1:0];
		d.cmd.write_value = wv;
		d.cmd.query_x = qx;
		d.cmd.query_y = qy;
		d.cmd.mode = m;
		d.rsp.result_value = ev;
		d.rsp.x_index = exi[IDX_W-1:0];
		d.rsp.y_index = eyi[IDX_W-1:0];
		return d;
	endfunction

	// fields not used by an opcode still get random bits
	function automatic cmd_item_t scratch_item();
		cmd_item_t c;
		c.opcode = op_t'($urandom_range(0, 3));
		c.address = $urandom_range(0, 1023);
		c.write_value = $urandom;
		c.query_x = $urandom;
		c.query_y = $urandom;
		c.mode = mode_t'($urandom_range(0, 3));
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 15);
		return $urandom_range(40, 150);
	endfunction

	function automatic int signed pick_table_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		if (r < 80)
			return $urandom;
		return (r < 90) ? Q_MAX : Q_MIN;
	endfunction

	function automatic int signed pick_coord(input bit on_y, input int n);
		int i, r;
		int signed b, lo_v, hi_v;
		longint signed width, offset, pos;
		lo_v = Q_MAX;
		hi_v = Q_MIN;
		for (i = 0; i < n; i++) begin
			b = on_y ? y_bp[i] : x_bp[i];
			if (b < lo_v)
				lo_v = b;
			if (b > hi_v)
				hi_v = b;
		end
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
		if (r < 25) begin
			i = $urandom_range(0, n - 1);
			b = on_y ? y_bp[i] : x_bp[i];
			return clip_q(longint'(b) + int'($urandom_range(0, 2)) - 1);
		end
		if (r < 33)
			return $urandom;
		width = longint'(hi_v) - longint'(lo_v);
		offset = {$urandom, $urandom} % (width + width / 4 + 1);
		pos = longint'(lo_v) - width / 8 + offset;
		return clip_q(pos);
	endfunction

	task automatic issue(input cmd_item_t c, input bit typed_valid, input rsp_item_t typed);
		int gap;
		rsp_item_t r;
		gap = (idle_enabled && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		if (model_item(c, r))
			pending_results.push_back(typed_valid ? typed : r);
		if (c.opcode == OP_QUERY)
			mode_hits[c.mode]++;
		if (!((c.opcode == OP_WR_X && c.address >= MAX_X_POINTS) ||
			(c.opcode == OP_WR_Y && c.address >= MAX_Y_POINTS)))
			items_sent++;
	endtask

	// drain outstanding results, then let trailing writes finish
	task automatic settle();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [CNT_W-1:0] v);
		logic [31:0] word;
		word = $urandom;
		word[CNT_W-1:0] = v;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_X_COUNT)
			cfg_x_count = v;
		else
			cfg_y_count = v;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {{(32 - CNT_W){1'b0}}, v})
			flag_mismatch("count register readback", prdata, {{(32 - CNT_W){1'b0}}, v});
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_breaks(input bit on_y, input int n);
		int i, style;
		longint signed cur;
		int unsigned scale;
		cmd_item_t c;
		style = $urandom_range(0, 9);
		style = (style < 5) ? 0 : (style < 7) ? 1 : (style < 9) ? 2 : 3;
		cur = longint'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
		scale = $urandom_range(1, 32'h0004_0000);
		if (style == 1) begin
			// start at the bottom of the range, big steps run into the top
			cur = longint'(Q_MIN);
			scale = $urandom_range(32'h1000_0000, 32'h8000_0000);
		end
		for (i = 0; i < n; i++) begin
			c = scratch_item();
			c.opcode = on_y ? OP_WR_Y : OP_WR_X;
			c.address = i;
			c.write_value = (style == 3) ? int'($urandom) : clip_q(cur);
			if (style == 2)
				cur += longint'($urandom_range(0, 2)) * longint'(scale);
			else
				cur += longint'($urandom_range(1, scale));
			issue(c, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result with no query outstanding", rsp_ch.data.result_value, 0);
			end else begin
				oldest = pending_results.pop_front();
				results_checked++;
				if (rsp_ch.data.result_value !== oldest.result_value)
					flag_mismatch("result_value", rsp_ch.data.result_value, oldest.result_value);
				if (rsp_ch.data.x_index !== oldest.x_index)
					flag_mismatch("x_index", rsp_ch.data.x_index, oldest.x_index);
				if (rsp_ch.data.y_index !== oldest.y_index)
					flag_mismatch("y_index", rsp_ch.data.y_index, oldest.y_index);
			end
		end
	end

	// result sink: random stalls, plus one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left = pick_gap() - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int phase, want_x, want_y, nx, ny, a, k, n_q, r;
		cmd_item_t c;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_x_count = 1;
		cfg_y_count = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		directed = '{
			row(ROW_ITEM,  OP_WR_X,    0, 0, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_Y,    0, 0, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_GRID, 0, Q_MAX, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_CHECK, OP_QUERY,   0, 0, Q_MIN, Q_MIN, MODE_CORNER, Q_MAX, 0, 0),
			row(ROW_CHECK, OP_QUERY, 1023, Q_MIN, Q_MAX, Q_MAX, MODE_BILINEAR, Q_MAX, 0, 0),
			row(ROW_ITEM,  OP_WR_GRID, 1023, Q_MIN, 0, 0, MODE_CORNER, 0, 0, 0),
			// breakpoint indexes past the store are dropped
			row(ROW_ITEM,  OP_WR_X,    1023, 5, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_Y,    32, 7, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_GRID, 0, Q_MIN, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_CHECK, OP_QUERY,   0, 0, 0, 0, MODE_LERP_X, Q_MIN, 0, 0),
			row(ROW_CHECK, OP_QUERY,   0, 0, -1, 1, MODE_LERP_Y, Q_MIN, 0, 0),
			row(ROW_CFG,   OP_WR_X, int'(REG_X_COUNT), 2, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_CFG,   OP_WR_X, int'(REG_Y_COUNT), 2, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_X,    0, Q_MIN, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_X,    1, Q_MAX, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_Y,    1, Q_ONE, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_GRID, 0, Q_MIN, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_GRID, 1, Q_MAX, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_GRID, 2, Q_MAX, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_WR_GRID, 3, 0, 0, 0, MODE_CORNER, 0, 0, 0),
			row(ROW_ITEM,  OP_QUERY,   0, 0, 0, 32'h8000, MODE_LERP_X, 0, 0, 0),
			row(ROW_ITEM,  OP_QUERY,   0, 0, 0, 32'h8000, MODE_LERP_Y, 0, 0, 0),
			row(ROW_ITEM,  OP_QUERY,   0, 0, 0, 32'h8000, MODE_BILINEAR, 0, 0, 0),
			row(ROW_ITEM,  OP_QUERY,   0, 0, Q_MIN, Q_MIN, MODE_BILINEAR, 0, 0, 0),
			row(ROW_ITEM,  OP_QUERY,   0, 0, Q_MAX, Q_MAX, MODE_CORNER, 0, 0, 0)
		};

		foreach (directed[i]) begin
			case (directed[i].kind)
				ROW_CFG: begin
					settle();
					cfg_write(reg_idx_t'(directed[i].cmd.address[0]),
						directed[i].cmd.write_value[CNT_W-1:0]);
				end
				ROW_CHECK: issue(directed[i].cmd, 1'b1, directed[i].rsp);
				default: issue(directed[i].cmd, 1'b0, '0);
			endcase
		end

		// each phase: new counts, fresh breakpoints and table, then a query burst
		phase = 0;
		while (items_sent < 1700) begin
			if (phase < $size(sched_x)) begin
				want_x = sched_x[phase];
				want_y = sched_y[phase];
			end else begin
				want_x = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
				want_y = $urandom_range(1, 6);
			end
			idle_enabled = (phase % 5) != 2;
			settle();
			cfg_write(REG_X_COUNT, want_x[CNT_W-1:0]);
			cfg_write(REG_Y_COUNT, want_y[CNT_W-1:0]);
			nx = in_use(cfg_x_count, MAX_X_POINTS);
			ny = in_use(cfg_y_count, MAX_Y_POINTS);
			load_breaks(1'b0, nx);
			load_breaks(1'b1, ny);
			for (a = 0; a < nx * ny; a++) begin
				c = scratch_item();
				c.opcode = OP_WR_GRID;
				c.address = a;
				c.write_value = pick_table_value();
				issue(c, 1'b0, '0);
			end
			n_q = (nx * ny > 100) ? 25 : $urandom_range(30, 60);
			for (k = 0; k < n_q; k++) begin
				if (phase == 1 && k == 5)
					hold_off_request = 1'b1;
				if ($urandom_range(0, 6) == 0) begin
					c = scratch_item();
					r = $urandom_range(0, 9);
					if (r < 6) begin
						c.opcode = OP_WR_GRID;
						c.write_value = pick_table_value();
					end else begin
						// mostly dropped indexes; sometimes scrambles the order
						c.opcode = $urandom_range(0, 1) ? OP_WR_Y : OP_WR_X;
						c.address = (r < 9) ? $urandom_range(32, 1023) : $urandom_range(0, 31);
					end
					issue(c, 1'b0, '0);
				end
				c = scratch_item();
				c.opcode = OP_QUERY;
				c.query_x = pick_coord(1'b0, nx);
				c.query_y = pick_coord(1'b1, ny);
				issue(c, 1'b0, '0);
			end
			phase++;
		end
		phase_count = phase;

		settle();
		repeat (24) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("queries left without a result", pending_results.size(), 0);
		$display("ran %0d transactions over %0d table settings, %0d results checked",
			items_sent, phase_count, results_checked);
		$display("queries by mode: corner %0d, along x %0d, along y %0d, bilinear %0d",
			mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		if (mismatch_count == 0)
			$display("table_bilinear_interpolator: match");
		else
			$display("table_bilinear_interpolator: mismatch");
		$finish;
	end

endmodule

// File: sim.f
src/tbi_pkg.sv
src/tbi_cmd_if.sv
src/tbi_rsp_if.sv
src/tbi_div.sv
src/table_bilinear_interpolator.sv
dv/testbench.sv
